// ===== rtl/ame_pkg.sv =====
// ----------------------------------------------------------------------------
// ame_pkg
// Shared widths, opcodes, state and command types of the accumulator machine
// executor.
// ----------------------------------------------------------------------------
`default_nettype none

package ame_pkg;

  localparam int REQ_W      = 7;
  localparam int ADDR_W     = 7;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int DATA_WORDS = 100;
  localparam int DIV_STEPS  = DATA_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [REQ_W-1:0] OPC_READ  = 7'd10;
  localparam logic [REQ_W-1:0] OPC_WRITE = 7'd11;
  localparam logic [REQ_W-1:0] OPC_LOAD  = 7'd20;
  localparam logic [REQ_W-1:0] OPC_STORE = 7'd21;
  localparam logic [REQ_W-1:0] OPC_ADD   = 7'd30;
  localparam logic [REQ_W-1:0] OPC_SUB   = 7'd31;
  localparam logic [REQ_W-1:0] OPC_MUL   = 7'd32;
  localparam logic [REQ_W-1:0] OPC_DIV   = 7'd33;
  localparam logic [REQ_W-1:0] OPC_HALT  = 7'd43;
  localparam logic [REQ_W-1:0] OPC_GRP_LO = 7'd10;
  localparam logic [REQ_W-1:0] OPC_GRP_HI = 7'd49;

  typedef enum logic [3:0] {
    OP_READ,
    OP_WRITE,
    OP_LOAD,
    OP_STORE,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_HALT,
    OP_NOP,
    OP_INVALID,
    OP_IGNORE
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_INVALID = 3'd1,
    STS_DIVZERO = 3'd2,
    STS_HALTED  = 3'd3,
    STS_IGNORED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DIVFIN,
    ST_POST
  } state_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic div_step;
    logic div_fin;
    logic post;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic w_zero;
    logic div_last;
    logic out_free;
  } sts_t;

  function automatic op_t decode_op(input logic [REQ_W-1:0] req_type);
    op_t op;
    if (!(req_type inside {[OPC_GRP_LO:OPC_GRP_HI]})) begin
      op = OP_INVALID;
    end else begin
      case (req_type)
        OPC_READ:  op = OP_READ;
        OPC_WRITE: op = OP_WRITE;
        OPC_LOAD:  op = OP_LOAD;
        OPC_STORE: op = OP_STORE;
        OPC_ADD:   op = OP_ADD;
        OPC_SUB:   op = OP_SUB;
        OPC_MUL:   op = OP_MUL;
        OPC_DIV:   op = OP_DIV;
        OPC_HALT:  op = OP_HALT;
        default:   op = OP_NOP;
      endcase
    end
    return op;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ame_if.sv =====
// ----------------------------------------------------------------------------
// ame_if
// Valid/ready channels for instruction requests and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ame_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [ame_pkg::REQ_W-1:0]      req_type;
  logic        [ame_pkg::ADDR_W-1:0]     mem_addr;
  logic signed [ame_pkg::DATA_W-1:0]     in_value;

  modport source (output valid, output req_type, output mem_addr, output in_value,
                  input ready);
  modport sink (input valid, input req_type, input mem_addr, input in_value,
                output ready);
endinterface

interface ame_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  out_valid;
  logic signed [ame_pkg::DATA_W-1:0]     out_value;
  logic        [ame_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output out_valid, output out_value, output status,
                  input ready);
  modport sink (input valid, input out_valid, input out_value, input status,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ame_ram.sv =====
// ----------------------------------------------------------------------------
// ame_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_ram #(
  parameter int WIDTH = ame_pkg::DATA_W,
  parameter int DEPTH = ame_pkg::DATA_WORDS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ame_ctrl.sv =====
// ----------------------------------------------------------------------------
// ame_ctrl
// Sequencer: accepts a request, runs execute, the divide iterations and the
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ame_pkg::sts_t sts,
  output ame_pkg::cmd_t      cmd
);

  ame_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ame_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ame_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ame_pkg::ST_EXEC;
        end
      end
      ame_pkg::ST_EXEC: begin
        if (sts.op == ame_pkg::OP_DIV && !sts.w_zero) begin
          state_nxt = ame_pkg::ST_DIV;
        end else begin
          state_nxt = ame_pkg::ST_POST;
        end
      end
      ame_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ame_pkg::ST_DIVFIN;
        end
      end
      ame_pkg::ST_DIVFIN: state_nxt = ame_pkg::ST_POST;
      ame_pkg::ST_POST: begin
        if (sts.out_free) begin
          state_nxt = ame_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ame_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ame_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ame_pkg::ST_EXEC:   cmd.exec     = 1'b1;
      ame_pkg::ST_DIV:    cmd.div_step = 1'b1;
      ame_pkg::ST_DIVFIN: cmd.div_fin  = 1'b1;
      ame_pkg::ST_POST:   cmd.post     = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ame_dp.sv =====
// ----------------------------------------------------------------------------
// ame_dp
// Datapath: data store with word valid bits, accumulator, multiplier,
// bit-serial divider, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_dp #(
  parameter int DATA_WORDS = ame_pkg::DATA_WORDS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ame_pkg::cmd_t                       cmd,
  output ame_pkg::sts_t                            sts,
  input  wire logic        [ame_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic        [ame_pkg::ADDR_W-1:0]   in_mem_addr,
  input  wire logic signed [ame_pkg::DATA_W-1:0]   in_value,
  input  wire logic                                out_ready,
  output logic                                     out_vld,
  output logic                                     out_flag,
  output logic signed      [ame_pkg::DATA_W-1:0]   out_value,
  output logic             [ame_pkg::STATUS_W-1:0] out_status
);

  localparam int AW     = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int AddrW  = ame_pkg::ADDR_W;
  localparam int DW     = ame_pkg::DATA_W;
  localparam int CW     = ame_pkg::CNT_W;
  localparam logic [AddrW-1:0] ADDR_LIM = AddrW'(DATA_WORDS);
  localparam logic [CW-1:0]    CNT_LAST = CW'(ame_pkg::DIV_STEPS - 1);

  ame_pkg::op_t     op_r;
  logic [AW-1:0]    addr_r;
  logic             inr_r;
  logic [DW-1:0]    val_r;
  logic             rdok_r;
  logic [DW-1:0]    acc_r, acc_nxt;
  logic             halted_r;
  logic [DATA_WORDS-1:0] wvld_r;
  logic [DW-1:0]    quo_r, rem_r, dvs_r;
  logic             neg_r;
  logic [CW-1:0]    cnt_r;
  logic             pflag_r;
  logic [DW-1:0]    pvalue_r;
  ame_pkg::status_t pstatus_r;
  logic             ov_r;

  logic [DW-1:0]    rd_data;
  logic [DW-1:0]    w;
  logic             take_inr;
  logic [AW-1:0]    take_idx;
  logic             ram_we;
  logic [DW-1:0]    ram_wdata;
  logic [DW:0]      rem_sh;
  logic             rem_ge;

  assign take_inr = in_mem_addr < ADDR_LIM;
  assign take_idx = in_mem_addr[AW-1:0];
  assign w        = rdok_r ? rd_data : '0;

  assign ram_we    = cmd.exec && inr_r &&
                     (op_r == ame_pkg::OP_READ || op_r == ame_pkg::OP_STORE);
  assign ram_wdata = (op_r == ame_pkg::OP_READ) ? val_r : acc_r;

  ame_ram #(
    .WIDTH(DW),
    .DEPTH(DATA_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_r),
    .wdata(ram_wdata),
    .re   (cmd.take),
    .raddr(take_idx),
    .rdata(rd_data)
  );

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.exec) begin
      case (op_r)
        ame_pkg::OP_LOAD: acc_nxt = w;
        ame_pkg::OP_ADD:  acc_nxt = acc_r + w;
        ame_pkg::OP_SUB:  acc_nxt = acc_r - w;
        ame_pkg::OP_MUL:  acc_nxt = DW'(acc_r * w);
        default:          acc_nxt = acc_r;
      endcase
    end else if (cmd.div_fin) begin
      acc_nxt = neg_r ? (~quo_r + 1'b1) : quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      halted_r <= 1'b0;
      wvld_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      if (cmd.exec && op_r == ame_pkg::OP_HALT) begin
        halted_r <= 1'b1;
      end
      if (ram_we) begin
        wvld_r[addr_r] <= 1'b1;
      end
      if (cmd.post) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= halted_r ? ame_pkg::OP_IGNORE : ame_pkg::decode_op(in_req_type);
      addr_r <= take_idx;
      inr_r  <= take_inr;
      val_r  <= in_value;
      rdok_r <= take_inr && wvld_r[take_idx];
    end
    if (cmd.exec) begin
      pflag_r   <= 1'b0;
      pvalue_r  <= '0;
      pstatus_r <= ame_pkg::STS_OK;
      quo_r     <= acc_r[DW-1] ? (~acc_r + 1'b1) : acc_r;
      dvs_r     <= w[DW-1] ? (~w + 1'b1) : w;
      rem_r     <= '0;
      neg_r     <= acc_r[DW-1] ^ w[DW-1];
      cnt_r     <= '0;
      case (op_r)
        ame_pkg::OP_WRITE: begin
          pflag_r  <= 1'b1;
          pvalue_r <= w;
        end
        ame_pkg::OP_DIV: begin
          if (w == '0) begin
            pstatus_r <= ame_pkg::STS_DIVZERO;
          end
        end
        ame_pkg::OP_HALT:    pstatus_r <= ame_pkg::STS_HALTED;
        ame_pkg::OP_INVALID: pstatus_r <= ame_pkg::STS_INVALID;
        ame_pkg::OP_IGNORE:  pstatus_r <= ame_pkg::STS_IGNORED;
        default:             pstatus_r <= ame_pkg::STS_OK;
      endcase
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? DW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DW-1:0];
      quo_r <= {quo_r[DW-2:0], rem_ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.post) begin
      out_flag   <= pflag_r;
      out_value  <= pvalue_r;
      out_status <= pstatus_r;
    end
  end

  assign out_vld = ov_r;

  always_comb begin
    sts.op       = op_r;
    sts.w_zero   = (w == '0);
    sts.div_last = (cnt_r == CNT_LAST);
    sts.out_free = !ov_r || out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/accumulator_machine_executor_top.sv =====
// A non-divide request or a divide by zero goes from acceptance through the execute
// and post states; post loads the output register, waiting while a stalled result holds it.
// Any other divide runs a one-bit-per-cycle restoring divider and a sign fix-up
// state before post; a new request is taken only once the controller is idle again.
// Synchronous active-low reset clears the accumulator, the halt flag, the
// data store (through per-word valid bits) and the output valid flag at once.
// ----------------------------------------------------------------------------
// accumulator_machine_executor_top
// Accumulator machine that executes one decoded instruction per request.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_machine_executor_top #(
  parameter int DATA_WORDS = ame_pkg::DATA_WORDS
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ame_req_if.sink    in_ch,
  ame_rsp_if.source  out_ch
);

  ame_pkg::cmd_t cmd;
  ame_pkg::sts_t sts;

  ame_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ame_dp #(
    .DATA_WORDS(DATA_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req_type(in_ch.req_type),
    .in_mem_addr(in_ch.mem_addr),
    .in_value   (in_ch.in_value),
    .out_ready  (out_ch.ready),
    .out_vld    (out_ch.valid),
    .out_flag   (out_ch.out_valid),
    .out_value  (out_ch.out_value),
    .out_status (out_ch.status)
  );

endmodule

`default_nettype wire

// ===== rtl/ame_checker.sv =====
// ----------------------------------------------------------------------------
// ame_checker
// Port-level checks of the accumulator machine executor, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ame_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_vld,
  input wire logic                                out_ready,
  input wire logic                                out_flag,
  input wire logic        [ame_pkg::DATA_W-1:0]   out_value,
  input wire logic        [ame_pkg::STATUS_W-1:0] out_status
);

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_vld)
    else $error("Output valid after reset.");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request accepted while another is in progress.");

  a_emit_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_flag |-> out_status == ame_pkg::STS_OK)
    else $error("Emitted word carries a non-ok status.");

  a_no_emit_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_flag |-> out_value == '0)
    else $error("Non-emitting result carries a nonzero value.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_ready |=> out_vld && $stable(out_flag) && $stable(out_value) &&
                              $stable(out_status))
    else $error("Stalled result changed.");

endmodule

bind accumulator_machine_executor_top ame_checker u_ame_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_vld   (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_flag  (out_ch.out_valid),
  .out_value (out_ch.out_value),
  .out_status(out_ch.status)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the accumulator machine executor. A shadow copy
// of the data store, accumulator and halt flag predicts the result of every
// accepted request, and each returned result is compared with the oldest
// prediction. A directed opening covers the boundary values and corner cases,
// random instruction streams follow under three idling patterns, and the run
// ends with a halt and a burst of requests that must be ignored.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int REQ_W           = ame_pkg::REQ_W;
  localparam int ADDR_W          = ame_pkg::ADDR_W;
  localparam int DATA_W          = ame_pkg::DATA_W;
  localparam int STATUS_W        = ame_pkg::STATUS_W;
  localparam int DATA_WORDS      = ame_pkg::DATA_WORDS;
  localparam int RANDOM_REQUESTS = 1050;
  localparam int AFTER_HALT      = 16;
  localparam int DRAIN_CYCLES    = 48;
  localparam int STALL_LIMIT     = 4000;
  localparam int ADDR_MAX        = (1 << ADDR_W) - 1;
  localparam int REQ_MAX         = (1 << REQ_W) - 1;
  localparam logic [REQ_W-1:0]  OPC_BRANCH = 7'd40;
  localparam logic [REQ_W-1:0]  OPC_ZERO   = 7'd0;
  localparam logic [REQ_W-1:0]  OPC_BELOW  = ame_pkg::OPC_GRP_LO - 1'b1;
  localparam logic [REQ_W-1:0]  OPC_ABOVE  = ame_pkg::OPC_GRP_HI + 1'b1;
  localparam logic [REQ_W-1:0]  OPC_TOP    = REQ_W'(REQ_MAX);
  localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(DATA_WORDS - 1);
  localparam logic [ADDR_W-1:0] TOP_ADDR   = ADDR_W'(ADDR_MAX);

  typedef struct {
    logic                out_valid;
    logic [DATA_W-1:0]   out_value;
    ame_pkg::status_t    status;
  } result_t;

  class executor_shadow;
    logic [DATA_W-1:0] words [DATA_WORDS];
    logic [DATA_W-1:0] acc;
    bit                halted;
    result_t           pending[$];
    int                mismatches;
    int                checked;

    function new();
      foreach (words[i]) words[i] = '0;
      acc        = '0;
      halted     = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function logic [DATA_W-1:0] fetch(logic [ADDR_W-1:0] addr);
      return (addr < DATA_WORDS) ? words[addr] : '0;
    endfunction

    function void put(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
      if (addr < DATA_WORDS) words[addr] = value;
    endfunction

    function void execute(logic [REQ_W-1:0] op, logic [ADDR_W-1:0] addr,
                          logic [DATA_W-1:0] value);
      result_t           r;
      logic [DATA_W-1:0] w;
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
      logic [DATA_W-1:0] quo;
      r.out_valid = 1'b0;
      r.out_value = '0;
      r.status    = ame_pkg::STS_OK;
      w = fetch(addr);
      if (halted) begin
        r.status = ame_pkg::STS_IGNORED;
      end else begin
        case (op)
          ame_pkg::OPC_READ:  put(addr, value);
          ame_pkg::OPC_WRITE: begin
            r.out_valid = 1'b1;
            r.out_value = w;
          end
          ame_pkg::OPC_LOAD:  acc = w;
          ame_pkg::OPC_STORE: put(addr, acc);
          ame_pkg::OPC_ADD:   acc = acc + w;
          ame_pkg::OPC_SUB:   acc = acc - w;
          ame_pkg::OPC_MUL:   acc = acc * w;
          ame_pkg::OPC_DIV: begin
            if (w == '0) begin
              r.status = ame_pkg::STS_DIVZERO;
            end else begin
              num = acc[DATA_W-1] ? -acc : acc;
              den = w[DATA_W-1] ? -w : w;
              quo = num / den;
              acc = (acc[DATA_W-1] ^ w[DATA_W-1]) ? -quo : quo;
            end
          end
          ame_pkg::OPC_HALT: begin
            halted   = 1'b1;
            r.status = ame_pkg::STS_HALTED;
          end
          default: begin
            if (!(op inside {[ame_pkg::OPC_GRP_LO:ame_pkg::OPC_GRP_HI]})) begin
              r.status = ame_pkg::STS_INVALID;
            end
          end
        endcase
      end
      pending = {pending, r};
    endfunction

    function void check_result(logic out_valid, logic [DATA_W-1:0] out_value,
                               logic [STATUS_W-1:0] status);
      result_t exp;
      checked++;
      if (pending.size() == 0) begin
        $error("Result with no request outstanding: out_valid %0b out_value %h status %0d",
               out_valid, out_value, status);
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      if (out_valid !== exp.out_valid) begin
        $error("out_valid: expected %0b, actual %0b", exp.out_valid, out_valid);
        mismatches++;
      end
      if (out_value !== exp.out_value) begin
        $error("out_value: expected %h, actual %h", exp.out_value, out_value);
        mismatches++;
      end
      if (status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ame_req_if req_ch ();
  ame_rsp_if rsp_ch ();

  accumulator_machine_executor_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  executor_shadow shadow = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int requests_sent = 0;
  int stall_cycles  = 0;

  always #5 clk = ~clk;

  task automatic send_request(logic [REQ_W-1:0] op, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.mem_addr <= addr;
    req_ch.in_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shadow.execute(op, addr, value);
    requests_sent++;
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 9))
      7, 8:    return ADDR_W'($urandom_range(0, DATA_WORDS - 1));
      9:       return ADDR_W'($urandom_range(DATA_WORDS, ADDR_MAX));
      default: return ADDR_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    logic [REQ_W-1:0] op;
    case ($urandom_range(0, 14))
      0, 1, 2, 3: op = ame_pkg::OPC_READ;
      4, 5:       op = ame_pkg::OPC_WRITE;
      6:          op = ame_pkg::OPC_LOAD;
      7:          op = ame_pkg::OPC_STORE;
      8:          op = ame_pkg::OPC_ADD;
      9:          op = ame_pkg::OPC_SUB;
      10:         op = ame_pkg::OPC_MUL;
      11, 12:     op = ame_pkg::OPC_DIV;
      13: begin
        do begin
          op = REQ_W'($urandom_range(ame_pkg::OPC_GRP_LO, ame_pkg::OPC_GRP_HI));
        end while (op inside {ame_pkg::OPC_READ, ame_pkg::OPC_WRITE, ame_pkg::OPC_LOAD,
                              ame_pkg::OPC_STORE, ame_pkg::OPC_ADD, ame_pkg::OPC_SUB,
                              ame_pkg::OPC_MUL, ame_pkg::OPC_DIV, ame_pkg::OPC_HALT});
      end
      default: begin
        if ($urandom_range(0, 1) == 0) op = REQ_W'($urandom_range(0, OPC_BELOW));
        else op = REQ_W'($urandom_range(OPC_ABOVE, REQ_MAX));
      end
    endcase
    send_request(op, pick_addr(), pick_word());
  endtask

  initial begin
    forever begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        shadow.check_result(rsp_ch.out_valid, rsp_ch.out_value, rsp_ch.status);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("accumulator_machine_executor_top test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= '0;
    req_ch.mem_addr <= '0;
    req_ch.in_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 75;

    send_request(ame_pkg::OPC_WRITE, 7'd0, '0);
    send_request(ame_pkg::OPC_WRITE, LAST_WORD, '0);
    send_request(ame_pkg::OPC_READ, 7'd0, 32'h7FFF_FFFF);
    send_request(ame_pkg::OPC_READ, LAST_WORD, 32'h8000_0000);
    send_request(ame_pkg::OPC_READ, TOP_ADDR, 32'hFFFF_FFFF);
    send_request(ame_pkg::OPC_WRITE, TOP_ADDR, '0);
    send_request(ame_pkg::OPC_WRITE, LAST_WORD, '0);
    send_request(ame_pkg::OPC_LOAD, LAST_WORD, '0);
    send_request(ame_pkg::OPC_READ, 7'd1, 32'hFFFF_FFFF);
    send_request(ame_pkg::OPC_DIV, 7'd1, '0);
    send_request(ame_pkg::OPC_DIV, 7'd2, '0);
    send_request(ame_pkg::OPC_ADD, 7'd0, '0);
    send_request(ame_pkg::OPC_SUB, LAST_WORD, '0);
    send_request(ame_pkg::OPC_MUL, 7'd1, '0);
    send_request(ame_pkg::OPC_STORE, 7'd5, 32'h5555_AAAA);
    send_request(ame_pkg::OPC_WRITE, 7'd5, '0);
    send_request(ame_pkg::OPC_READ, 7'd3, 32'd7);
    send_request(ame_pkg::OPC_DIV, 7'd3, '0);
    send_request(OPC_BRANCH, 7'd9, 32'h1234_5678);
    send_request(ame_pkg::OPC_GRP_HI, 7'd9, '0);
    send_request(OPC_ZERO, 7'd0, '0);
    send_request(OPC_BELOW, 7'd4, '0);
    send_request(OPC_ABOVE, 7'd4, '0);
    send_request(OPC_TOP, TOP_ADDR, 32'hFFFF_FFFF);
    send_request(ame_pkg::OPC_LOAD, 7'd120, '0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 27;
      end else if (i == 2 * RANDOM_REQUESTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_request();
    end

    send_request(ame_pkg::OPC_HALT, pick_addr(), pick_word());
    for (int i = 0; i < AFTER_HALT; i++) begin
      send_request(REQ_W'($urandom_range(0, REQ_MAX)), ADDR_W'($urandom_range(0, ADDR_MAX)),
                   $urandom);
    end
    req_ch.valid <= 1'b0;

    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Executed %0d instructions, %0d of them after halt; %0d results checked.",
             requests_sent, AFTER_HALT, shadow.checked);
    $display("Random streams ran with sender-heavy, receiver-heavy and no idling.");
    if (shadow.mismatches == 0) begin
      $display("accumulator_machine_executor_top test passed");
    end else begin
      $display("accumulator_machine_executor_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ame_pkg.sv
rtl/ame_if.sv
rtl/ame_ram.sv
rtl/ame_ctrl.sv
rtl/ame_dp.sv
rtl/accumulator_machine_executor_top.sv
rtl/ame_checker.sv
tb/tb_top.sv
